// ----- design/mos_pkg.sv -----
// Shared constants and types for the median-of-samples block.
package mos_pkg;

    localparam int CAPACITY   = 1024;
    localparam int VALUE_BITS = 32;
    localparam int ADDR_W     = $clog2(CAPACITY);
    localparam int CNT_W      = $clog2(CAPACITY + 1);
    localparam int OUT_CNT_W  = 11;
    localparam int TDATA_OUT_W = 48;

    localparam logic [VALUE_BITS-1:0] SIGN_BIT = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // sequencer states, one-hot
    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_RD    = 8'b0000_0010,
        ST_CMP   = 8'b0000_0100,
        ST_WR    = 8'b0000_1000,
        ST_MED_A = 8'b0001_0000,
        ST_MED_B = 8'b0010_0000,
        ST_MED_C = 8'b0100_0000,
        ST_FIN   = 8'b1000_0000
    } state_t;

    // result handed from the sequencer to the output register
    typedef struct packed {
        logic                  valid;
        logic [VALUE_BITS-1:0] median;
        logic [OUT_CNT_W-1:0]  count;
        logic                  empty;
    } result_t;

endpackage

// ----- design/mos_store.sv -----
// Sorted sample store: one write port, one read port with registered data.
module mos_store (
    input  logic                           aclk,
    input  logic                           wr_en,
    input  logic [mos_pkg::ADDR_W-1:0]     wr_addr,
    input  logic [mos_pkg::VALUE_BITS-1:0] wr_data,
    input  logic [mos_pkg::ADDR_W-1:0]     rd_addr,
    output logic [mos_pkg::VALUE_BITS-1:0] rd_data
);

    logic [mos_pkg::VALUE_BITS-1:0] mem [mos_pkg::CAPACITY];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ----- design/mos_alu.sv -----
// Shared unit: unsigned compare and floor midpoint of two offset-binary keys.
module mos_alu (
    input  logic [mos_pkg::VALUE_BITS-1:0] op_a,
    input  logic [mos_pkg::VALUE_BITS-1:0] op_b,
    output logic                           a_gt_b,
    output logic [mos_pkg::VALUE_BITS-1:0] midpoint
);

    assign a_gt_b   = op_a > op_b;
    // floor((a + b) / 2) without a carry out
    assign midpoint = (op_a & op_b) + ((op_a ^ op_b) >> 1);

endmodule

// ----- design/mos_seq.sv -----
// Sequencer: ordered insert by shifting one entry per step, then median read.
module mos_seq (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           item_valid,
    output logic                           item_ready,
    input  logic [mos_pkg::VALUE_BITS-1:0] item_sample,
    input  logic                           item_last,
    output mos_pkg::result_t               result,
    input  logic                           result_take
);

    mos_pkg::state_t state_reg, state_next;

    logic [mos_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [mos_pkg::CNT_W-1:0]      j_reg, j_next;
    logic [mos_pkg::VALUE_BITS-1:0] key_reg, key_next;
    logic                           last_reg, last_next;
    logic [mos_pkg::VALUE_BITS-1:0] lo_reg, lo_next;
    logic [mos_pkg::VALUE_BITS-1:0] med_reg, med_next;
    logic                           empty_reg, empty_next;

    logic                           wr_en;
    logic [mos_pkg::ADDR_W-1:0]     wr_addr;
    logic [mos_pkg::VALUE_BITS-1:0] wr_data;
    logic [mos_pkg::ADDR_W-1:0]     rd_addr;
    logic [mos_pkg::VALUE_BITS-1:0] rd_data;
    logic [mos_pkg::VALUE_BITS-1:0] alu_a, alu_b, alu_mid;
    logic                           alu_gt;
    logic [mos_pkg::ADDR_W-1:0]     half;
    logic [mos_pkg::CNT_W-1:0]      j_dec;

    mos_store u_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mos_alu u_alu (
        .op_a     (alu_a),
        .op_b     (alu_b),
        .a_gt_b   (alu_gt),
        .midpoint (alu_mid)
    );

    assign half  = mos_pkg::ADDR_W'(count_reg >> 1);
    assign j_dec = j_reg - mos_pkg::CNT_W'(1);

    assign item_ready = state_reg == mos_pkg::ST_IDLE;

    assign result.valid  = state_reg == mos_pkg::ST_FIN;
    assign result.median = med_reg;
    assign result.count  = mos_pkg::OUT_CNT_W'(count_reg);
    assign result.empty  = empty_reg;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        j_next     = j_reg;
        key_next   = key_reg;
        last_next  = last_reg;
        lo_next    = lo_reg;
        med_next   = med_reg;
        empty_next = empty_reg;
        wr_en      = 1'b0;
        wr_addr    = mos_pkg::ADDR_W'(j_reg);
        wr_data    = key_reg;
        rd_addr    = mos_pkg::ADDR_W'(j_dec);
        alu_a      = rd_data;
        alu_b      = key_reg;

        case (state_reg)
            mos_pkg::ST_IDLE: begin
                if (item_valid) begin
                    key_next  = item_sample ^ mos_pkg::SIGN_BIT;
                    last_next = item_last;
                    j_next    = count_reg;
                    if (count_reg < mos_pkg::CNT_W'(mos_pkg::CAPACITY)) begin
                        state_next = (count_reg == '0) ? mos_pkg::ST_WR : mos_pkg::ST_RD;
                    end else if (item_last) begin
                        state_next = mos_pkg::ST_MED_A;
                    end
                end
            end
            mos_pkg::ST_RD: begin
                state_next = mos_pkg::ST_CMP;
            end
            mos_pkg::ST_CMP: begin
                if (alu_gt) begin
                    // move the larger entry up one place
                    wr_en      = 1'b1;
                    wr_data    = rd_data;
                    j_next     = j_dec;
                    state_next = (j_dec == '0) ? mos_pkg::ST_WR : mos_pkg::ST_RD;
                end else begin
                    state_next = mos_pkg::ST_WR;
                end
            end
            mos_pkg::ST_WR: begin
                wr_en      = 1'b1;
                count_next = count_reg + mos_pkg::CNT_W'(1);
                state_next = last_reg ? mos_pkg::ST_MED_A : mos_pkg::ST_IDLE;
            end
            mos_pkg::ST_MED_A: begin
                rd_addr = count_reg[0] ? half : half - mos_pkg::ADDR_W'(1);
                if (count_reg == '0) begin
                    med_next   = '0;
                    empty_next = 1'b1;
                    state_next = mos_pkg::ST_FIN;
                end else begin
                    empty_next = 1'b0;
                    state_next = mos_pkg::ST_MED_B;
                end
            end
            mos_pkg::ST_MED_B: begin
                rd_addr = half;
                if (count_reg[0]) begin
                    med_next   = rd_data ^ mos_pkg::SIGN_BIT;
                    state_next = mos_pkg::ST_FIN;
                end else begin
                    lo_next    = rd_data;
                    state_next = mos_pkg::ST_MED_C;
                end
            end
            mos_pkg::ST_MED_C: begin
                alu_a      = lo_reg;
                alu_b      = rd_data;
                med_next   = alu_mid ^ mos_pkg::SIGN_BIT;
                state_next = mos_pkg::ST_FIN;
            end
            mos_pkg::ST_FIN: begin
                if (result_take) begin
                    count_next = '0;
                    state_next = mos_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = mos_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mos_pkg::ST_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        j_reg     <= j_next;
        key_reg   <= key_next;
        last_reg  <= last_next;
        lo_reg    <= lo_next;
        med_reg   <= med_next;
        empty_reg <= empty_next;
    end

endmodule

// ----- design/median_of_samples_top.sv -----
// Top level of the median-of-samples block: sequencer plus output register.
// Usage:
//   Input stream (s_): one signed Q16.16 sample per item in s_tdata[31:0];
//   s_tlast marks the final sample of a set. Samples are kept in ascending
//   order in a 1024-entry store; samples beyond 1024 in one set are dropped.
//   Result stream (m_): one item per marked input item. m_tdata[31:0] is the
//   median (odd count: middle entry; even count: floor of the mean of the two
//   middle entries), m_tdata[42:32] the number of samples used, m_tuser set
//   when the set held no sample (median and count zero then).
// Sequence (s_tready is low while an item is in work):
//   An insert reads and compares stored entries from the top down, shifting
//   each larger one up a place, then writes the sample, in one
//   read/compare/write loop over the store's single read and write port.
//   A full store drops a sample without an insert. A marked item then reads
//   the middle entry (odd count) or the two middle entries and their midpoint
//   (even count) for the median; m_tvalid rises as s_tready returns.
// Reset and stall:
//   aresetn (synchronous, active low) empties the store count and drops any
//   pending result. The result sits in an output register; the next item is
//   accepted while it waits, and a further result waits in the sequencer
//   until the register frees up, holding s_tready low meanwhile.
module median_of_samples_top (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [31:0]                     s_tdata,  // [31:0] sample_value
    input  logic                            s_tlast,  // last_of_set
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [31:0] median_value, [42:32] sample_count, [47:43] zero
    output logic [mos_pkg::TDATA_OUT_W-1:0] m_tdata,
    output logic                            m_tuser   // set_empty
);

    mos_pkg::result_t result;
    logic             result_take;

    logic                            m_valid_reg;
    logic [mos_pkg::TDATA_OUT_W-1:0] m_data_reg;
    logic                            m_user_reg;

    mos_seq u_seq (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .item_valid  (s_tvalid),
        .item_ready  (s_tready),
        .item_sample (s_tdata[mos_pkg::VALUE_BITS-1:0]),
        .item_last   (s_tlast),
        .result      (result),
        .result_take (result_take)
    );

    // output register loads when empty or being drained this cycle
    assign result_take = result.valid && (!m_valid_reg || m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (result_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (result_take) begin
            m_data_reg <= mos_pkg::TDATA_OUT_W'({result.count, result.median});
            m_user_reg <= result.empty;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule
